// ===== src/strs_pkg.sv =====
`timescale 1ns / 1ps

package strs_pkg;

    // Datapath operation codes issued by the controller.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_WR_LEAF  = 4'd2;
    localparam logic [3:0] OP_RD_SIB   = 4'd3;
    localparam logic [3:0] OP_WR_PAR   = 4'd4;
    localparam logic [3:0] OP_RD_L     = 4'd5;
    localparam logic [3:0] OP_ADD_L    = 4'd6;
    localparam logic [3:0] OP_RD_R     = 4'd7;
    localparam logic [3:0] OP_ADD_R    = 4'd8;
    localparam logic [3:0] OP_SHIFT    = 4'd9;
    localparam logic [3:0] OP_CLR      = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACTIVE_LENGTH = 2'd0;

    localparam int          MAX_ELEMENTS_DEF   = 1024;
    localparam logic [10:0] ACTIVE_LENGTH_RST  = 11'd1024;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic [3:0] op;
        logic       clr_init;
        logic       out_push;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic item_ok;
        logic k_root;
        logic l_lt_r;
        logic l_odd;
        logic r_odd;
        logic clr_last;
    } t_dp_status;

endpackage

// ===== src/strs_datapath.sv =====
`timescale 1ns / 1ps

module strs_datapath #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                 i_clk,
    input  strs_pkg::t_dp_cmd    i_cmd,
    output strs_pkg::t_dp_status o_status,
    input  logic [10:0]          i_n_eff,
    input  logic                 i_item_cmd,
    input  logic [9:0]           i_element_index,
    input  logic [31:0]          i_new_value,
    input  logic [9:0]           i_range_low,
    input  logic [9:0]           i_range_high,
    output logic [31:0]          o_sum
);
    import strs_pkg::*;

    localparam int LW    = (MAX_ELEMENTS <= 2) ? 1 : $clog2(MAX_ELEMENTS);
    localparam int P     = 1 << LW;
    localparam int NODES = 2 * P;
    localparam int AW    = LW + 1;
    localparam int NW    = LW + 2;

    logic [31:0]   mem [0:NODES-1];
    logic [31:0]   r_rdata;
    logic [NW-1:0] r_k, r_l, r_r;
    logic [31:0]   r_v, r_acc;
    logic          r_is_q, r_ok;
    logic [AW-1:0] r_cnt;

    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;
    logic          pos_ok, span_ok;
    logic [10:0]   b_clip;
    logic [10:0]   n_m1;

    assign n_m1    = i_n_eff - 11'd1;
    assign pos_ok  = (i_n_eff != 11'd0) && ({1'b0, i_element_index} < i_n_eff);
    assign span_ok = (i_n_eff != 11'd0) && (i_range_low <= i_range_high)
                     && ({1'b0, i_range_low} < i_n_eff);
    assign b_clip  = ({1'b0, i_range_high} > n_m1) ? n_m1 : {1'b0, i_range_high};

    always_comb begin
        we    = 1'b0;
        addr  = r_k[AW-1:0];
        wdata = r_v;
        unique case (i_cmd.op)
            OP_WR_LEAF: we = 1'b1;
            OP_RD_SIB:  addr = r_k[AW-1:0] ^ AW'(1);
            OP_WR_PAR: begin
                we    = 1'b1;
                addr  = r_k[AW:1];
                wdata = r_v + r_rdata;
            end
            OP_RD_L:    addr = r_l[AW-1:0];
            OP_RD_R:    addr = r_r[AW-1:0] - AW'(1);
            OP_CLR: begin
                we    = 1'b1;
                addr  = r_cnt;
                wdata = 32'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_init) begin
            r_cnt <= '0;
        end else if (i_cmd.op == OP_CLR) begin
            r_cnt <= r_cnt + AW'(1);
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_is_q <= i_item_cmd;
                r_ok   <= (i_item_cmd == CMD_QUERY) ? span_ok : pos_ok;
                r_k    <= NW'(P) + NW'(i_element_index);
                r_v    <= i_new_value;
                r_l    <= NW'(P) + NW'(i_range_low);
                r_r    <= NW'(P) + NW'(b_clip) + NW'(1);
                r_acc  <= 32'd0;
            end
            OP_WR_PAR: begin
                r_v <= r_v + r_rdata;
                r_k <= r_k >> 1;
            end
            OP_ADD_L: begin
                r_acc <= r_acc + r_rdata;
                r_l   <= r_l + NW'(1);
            end
            OP_RD_R:  r_r <= r_r - NW'(1);
            OP_ADD_R: r_acc <= r_acc + r_rdata;
            OP_SHIFT: begin
                r_l <= r_l >> 1;
                r_r <= r_r >> 1;
            end
            default: ;
        endcase
    end

    assign o_status.is_query = r_is_q;
    assign o_status.item_ok  = r_ok;
    assign o_status.k_root   = (r_k == NW'(1));
    assign o_status.l_lt_r   = (r_l < r_r);
    assign o_status.l_odd    = r_l[0];
    assign o_status.r_odd    = r_r[0];
    assign o_status.clr_last = (r_cnt == {AW{1'b1}});
    assign o_sum             = r_acc;

endmodule

// ===== src/strs_controller.sv =====
`timescale 1ns / 1ps

module strs_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic                 i_take,
    input  logic                 i_out_free,
    input  strs_pkg::t_dp_status i_status,
    output strs_pkg::t_dp_cmd    o_cmd,
    output logic                 o_ready,
    output logic                 o_clearing,
    output logic                 o_done
);
    import strs_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_UWL  = 4'd3;
    localparam logic [3:0] S_UCHK = 4'd4;
    localparam logic [3:0] S_URD  = 4'd5;
    localparam logic [3:0] S_UWP  = 4'd6;
    localparam logic [3:0] S_QCHK = 4'd7;
    localparam logic [3:0] S_QRDL = 4'd8;
    localparam logic [3:0] S_QADL = 4'd9;
    localparam logic [3:0] S_QRCK = 4'd10;
    localparam logic [3:0] S_QRDR = 4'd11;
    localparam logic [3:0] S_QADR = 4'd12;
    localparam logic [3:0] S_QSH  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.clr_init = 1'b0;
        o_cmd.out_push = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_take) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.is_query) begin
                    n_state = i_status.item_ok ? S_QCHK : S_DONE;
                end else begin
                    n_state = i_status.item_ok ? S_UWL : S_IDLE;
                end
            end
            S_UWL: begin
                o_cmd.op = OP_WR_LEAF;
                n_state  = S_UCHK;
            end
            S_UCHK: n_state = i_status.k_root ? S_IDLE : S_URD;
            S_URD: begin
                o_cmd.op = OP_RD_SIB;
                n_state  = S_UWP;
            end
            S_UWP: begin
                o_cmd.op = OP_WR_PAR;
                n_state  = S_UCHK;
            end
            S_QCHK: begin
                priority if (!i_status.l_lt_r) begin
                    n_state = S_DONE;
                end else if (i_status.l_odd) begin
                    n_state = S_QRDL;
                end else if (i_status.r_odd) begin
                    n_state = S_QRDR;
                end else begin
                    n_state = S_QSH;
                end
            end
            S_QRDL: begin
                o_cmd.op = OP_RD_L;
                n_state  = S_QADL;
            end
            S_QADL: begin
                o_cmd.op = OP_ADD_L;
                n_state  = S_QRCK;
            end
            S_QRCK: n_state = i_status.r_odd ? S_QRDR : S_QSH;
            S_QRDR: begin
                o_cmd.op = OP_RD_R;
                n_state  = S_QADR;
            end
            S_QADR: begin
                o_cmd.op = OP_ADD_R;
                n_state  = S_QSH;
            end
            S_QSH: begin
                o_cmd.op = OP_SHIFT;
                n_state  = S_QCHK;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_push = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
        // Reset and a length write both restart the clearing pass at node zero.
        if (i_cfg_wr || !i_rst_n) begin
            o_cmd.clr_init = 1'b1;
            n_state        = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_clearing = (r_state == S_CLR);
    assign o_done     = (r_state == S_DONE);

endmodule

// ===== src/segment_tree_range_sum_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake             | Contents
// s_axis    | in        | tvalid/tready         | one update or query item
// m_axis    | out       | tvalid/tready         | one range sum per query
// apb       | in        | psel/penable/pready   | active_length register
//
// Flow: an item is taken only when the controller is idle. An update
// or a query runs to its end before ready rises again; P is MAX_ELEMENTS
// rounded up to a power of two, and the single-port node memory (one
// access per cycle, registered read) paces both walks through the tree.
// Reset and every write of active_length start a clearing pass over all
// 2*P nodes, one node per cycle, during which no item is accepted. A
// finished sum waits in the output register while the block returns to
// idle; a stall there holds only the next query.

module segment_tree_range_sum_unit #(
    parameter int MAX_ELEMENTS = strs_pkg::MAX_ELEMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] cmd, [10:1] element_index, [42:11] new_value,
    // [52:43] range_low, [62:53] range_high, [63] zero
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] range_sum
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import strs_pkg::*;

    logic [10:0] r_active_length;
    logic [10:0] n_eff;
    logic        cfg_wr, take, out_free, clearing, done;
    t_dp_cmd     cmd;
    t_dp_status  status;
    logic [31:0] sum;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_ACTIVE_LENGTH);
    assign prdata = (paddr == REG_ACTIVE_LENGTH) ? {21'd0, r_active_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= ACTIVE_LENGTH_RST;
        end else if (cfg_wr) begin
            r_active_length <= pwdata[10:0];
        end
    end

    // Lengths beyond the tree's capacity act as the capacity.
    assign n_eff = (32'(r_active_length) > MAX_ELEMENTS) ? 11'(MAX_ELEMENTS)
                                                         : r_active_length;

    assign take     = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    strs_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_take     (take),
        .i_out_free (out_free),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_ready    (s_axis_tready),
        .o_clearing (clearing),
        .o_done     (done)
    );

    strs_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_n_eff         (n_eff),
        .i_item_cmd      (s_axis_tdata[0]),
        .i_element_index (s_axis_tdata[10:1]),
        .i_new_value     (s_axis_tdata[42:11]),
        .i_range_low     (s_axis_tdata[52:43]),
        .i_range_high    (s_axis_tdata[62:53]),
        .o_sum           (sum)
    );

    // Output register: holds one finished sum until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_push) begin
            r_out_data <= sum;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // No item enters while the node memory is being cleared.
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !s_axis_tready)
        else $error("item accepted during clearing pass");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> !s_axis_tready)
        else $error("ready did not drop after a transfer");

    // A new result appears only after the controller finished a query.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(done))
        else $error("result shown without a finished query");

endmodule
